>>> sv/dq_pkg.sv
// shared constants, codes and controller/datapath interface types for the deque
`default_nettype none

package dq_pkg;

	localparam int DQ_CAPACITY = 16;
	localparam int OPCODE_W    = 3;
	localparam int DATA_W      = 32;
	localparam int COUNT_W     = 5;
	localparam int STATUS_W    = 2;

	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_PEEK       = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LOAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic load_out;
	} dq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
	} dq_sts_t;

endpackage

`default_nettype wire

>>> sv/dq_ram.sv
// generic ram: one write port, two read ports with registered read data
`default_nettype none

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic      [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

`default_nettype wire

>>> sv/dq_ctrl.sv
// sequencer for one deque operation: accept, update, read, load result
`default_nettype none

module dq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            out_stall,
	input  wire dq_pkg::dq_sts_t sts,
	output dq_pkg::dq_cmd_t      cmd
);

	import dq_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_free;

	assign out_free = !sts.out_full || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: state_nxt = S_READ;
			S_READ: state_nxt = S_LOAD;
			S_LOAD: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd.take     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_READ: ;
			S_LOAD: cmd.load_out = out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/dq_dpath.sv
// deque datapath: item registers, pointers, fill count, store and output register
`default_nettype none

module dq_dpath #(
	parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire dq_pkg::dq_cmd_t                     cmd,
	output dq_pkg::dq_sts_t                          sts,
	input  wire logic        [dq_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic signed [dq_pkg::DATA_W-1:0]    value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [dq_pkg::DATA_W-1:0]    front_value,
	output logic signed      [dq_pkg::DATA_W-1:0]    back_value,
	output logic             [dq_pkg::COUNT_W-1:0]   count,
	output logic                                     is_empty,
	output logic             [dq_pkg::STATUS_W-1:0]  status
);

	import dq_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
	endfunction

	logic [OPCODE_W-1:0] op_q;
	logic [DATA_W-1:0]   value_q;
	logic [PTR_W-1:0]    front_q;
	logic [PTR_W-1:0]    back_q;
	logic [CNT_W-1:0]    fill_q;
	status_t             status_q;
	logic                out_valid_q;

	logic [PTR_W-1:0] front_nxt;
	logic [PTR_W-1:0] back_nxt;
	logic [CNT_W-1:0] fill_nxt;
	status_t          status_nxt;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic             full;
	logic             empty;

	logic [DATA_W-1:0]      rd_front;
	logic [DATA_W-1:0]      rd_back;
	logic [CNT_W+COUNT_W-1:0] fill_ext;

	assign full  = (fill_q == CNT_W'(CAPACITY));
	assign empty = (fill_q == '0);

	always_comb begin
		front_nxt  = front_q;
		back_nxt   = back_q;
		fill_nxt   = fill_q;
		status_nxt = ST_OK;
		wr_en      = 1'b0;
		wr_addr    = back_q;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_PUSH_FULL;
				end else begin
					front_nxt = wrap_dec(front_q);
					wr_addr   = wrap_dec(front_q);
					wr_en     = cmd.exec;
					fill_nxt  = fill_q + 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_PUSH_FULL;
				end else begin
					back_nxt = wrap_inc(back_q);
					wr_en    = cmd.exec;
					fill_nxt = fill_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_nxt = ST_POP_EMPTY;
				end else begin
					front_nxt = wrap_inc(front_q);
					fill_nxt  = fill_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_nxt = ST_POP_EMPTY;
				end else begin
					back_nxt = wrap_dec(back_q);
					fill_nxt = fill_q - 1'b1;
				end
			end
			// peek and unused codes leave everything as is
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= opcode;
			value_q <= value;
		end
		if (cmd.exec) begin
			status_q <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			fill_q  <= '0;
		end else if (cmd.exec) begin
			front_q <= front_nxt;
			back_q  <= back_nxt;
			fill_q  <= fill_nxt;
		end
	end

	dq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (value_q),
		.rd_addr_a (front_q),
		.rd_data_a (rd_front),
		.rd_addr_b (wrap_dec(back_q)),
		.rd_data_b (rd_back)
	);

	// count field wraps when the fill count is wider than five bits
	assign fill_ext = {{COUNT_W{1'b0}}, fill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			front_value <= empty ? '1 : rd_front;
			back_value  <= empty ? '1 : rd_back;
			count       <= fill_ext[COUNT_W-1:0];
			is_empty    <= empty;
			status      <= status_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_full = out_valid_q;

endmodule

`default_nettype wire

>>> sv/double_ended_queue.sv
// top level of the bounded double-ended queue: controller, datapath and store
`default_nettype none

// Bounded double-ended queue of signed 32-bit values held in a circular buffer
// of CAPACITY entries. Each input item carries an opcode (push front, push back,
// pop front, pop back, peek; unused codes act as peek) and gives exactly one
// result item with the front and back values, the fill count, an empty flag and
// a status (ok, pop on empty ignored, push on full dropped). Front and back read
// all ones when the queue is empty; the count field wraps modulo 32 if CAPACITY
// is set above 31. One item is in work at a time and passes through the accept,
// an update state that writes the store and moves the pointers, a read state
// that issues both reads on the store's two registered read ports, and a load
// state that loads the output register. The output register lets the next
// item be accepted while a result still waits; the load state waits only if
// the previous result has not yet been taken. The store needs no clearing
// after reset: only counted entries are ever reported.

module double_ended_queue #(
	parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [dq_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic signed [dq_pkg::DATA_W-1:0]    value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [dq_pkg::DATA_W-1:0]    front_value,
	output logic signed      [dq_pkg::DATA_W-1:0]    back_value,
	output logic             [dq_pkg::COUNT_W-1:0]   count,
	output logic                                     is_empty,
	output logic             [dq_pkg::STATUS_W-1:0]  status
);

	import dq_pkg::*;

	// command and status between sequencer and datapath
	dq_cmd_t cmd;
	dq_sts_t sts;

	// sequencer: idle, update, read, load
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// pointers, fill count, entry store and output register
	dq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.is_empty    (is_empty),
		.status      (status)
	);

endmodule

`default_nettype wire

>>> dv/tb_double_ended_queue.sv
// self-checking testbench for the bounded double-ended queue
`default_nettype none

module tb_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	// one result item as the block reports it
	typedef struct {
		logic signed [DATA_W-1:0]  front;
		logic signed [DATA_W-1:0]  back;
		logic        [COUNT_W-1:0] cnt;
		logic                      empty;
		status_t                   st;
	} deque_view_t;

	// tracks the deque contents and the results still owed by the block
	class deque_scoreboard;
		logic signed [DATA_W-1:0] slots [DQ_CAPACITY];
		int unsigned head_idx;
		int unsigned tail_idx;
		int unsigned fill;
		deque_view_t owed [$];
		int unsigned failures;

		function new();
			head_idx = 0;
			tail_idx = 0;
			fill     = 0;
			failures = 0;
		endfunction

		// apply one accepted operation and queue the view it should produce
		function void note_input(logic [OPCODE_W-1:0] op, logic signed [DATA_W-1:0] v);
			deque_view_t want;
			want.st = ST_OK;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (fill >= DQ_CAPACITY) begin
						want.st = ST_PUSH_FULL;
					end else if (op == OP_PUSH_FRONT) begin
						head_idx = (head_idx == 0) ? DQ_CAPACITY - 1 : head_idx - 1;
						slots[head_idx] = v;
						fill++;
					end else begin
						slots[tail_idx] = v;
						tail_idx = (tail_idx + 1) % DQ_CAPACITY;
						fill++;
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (fill == 0) begin
						want.st = ST_POP_EMPTY;
					end else if (op == OP_POP_FRONT) begin
						head_idx = (head_idx + 1) % DQ_CAPACITY;
						fill--;
					end else begin
						tail_idx = (tail_idx == 0) ? DQ_CAPACITY - 1 : tail_idx - 1;
						fill--;
					end
				end
				default: ;
			endcase
			if (fill == 0) begin
				want.front = '1;
				want.back  = '1;
			end else begin
				want.front = slots[head_idx];
				want.back  = slots[(tail_idx + DQ_CAPACITY - 1) % DQ_CAPACITY];
			end
			want.cnt   = COUNT_W'(fill);
			want.empty = (fill == 0);
			owed.push_back(want);
		endfunction

		// compare one taken result with the oldest owed view
		function void check_result(deque_view_t got);
			deque_view_t want;
			if (owed.size() == 0) begin
				$display("%0t: result with nothing owed, front %h back %h count %0d",
					$time, got.front, got.back, got.cnt);
				failures++;
				return;
			end
			want = owed.pop_front();
			if (want.front !== got.front) begin
				$display("%0t: front_value expected %h actual %h", $time, want.front, got.front);
				failures++;
			end
			if (want.back !== got.back) begin
				$display("%0t: back_value expected %h actual %h", $time, want.back, got.back);
				failures++;
			end
			if (want.cnt !== got.cnt) begin
				$display("%0t: count expected %0d actual %0d", $time, want.cnt, got.cnt);
				failures++;
			end
			if (want.empty !== got.empty) begin
				$display("%0t: is_empty expected %b actual %b", $time, want.empty, got.empty);
				failures++;
			end
			if (want.st !== got.st) begin
				$display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic        [OPCODE_W-1:0]  opcode    = OP_PEEK;
	logic signed [DATA_W-1:0]    value     = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [DATA_W-1:0]    front_value;
	logic signed [DATA_W-1:0]    back_value;
	logic        [COUNT_W-1:0]   count;
	logic                        is_empty;
	logic        [STATUS_W-1:0]  status;

	// idle rates in percent for each side, changed per phase
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	// set by the stimulus to ask the receiver for one long hold-off
	bit          hold_req    = 1'b0;

	deque_scoreboard book = new();

	double_ended_queue DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.count       (count),
		.is_empty    (is_empty),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// values biased toward the extremes and all ones, which looks like the empty marker
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'sh8000_0000;
			3: return 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// offer one item, idling first at the current rate, and wait for the handshake;
	// sampled right after the edge, so in_stall still holds its pre-edge value
	task automatic offer_item(input logic [OPCODE_W-1:0] op, input logic signed [DATA_W-1:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			// junk on the payload while no item is offered
			in_valid <= 1'b0;
			opcode   <= OPCODE_W'($urandom_range(7));
			value    <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= v;
		do @(posedge clk); while (in_stall);
		book.note_input(op, v);
	endtask

	// random traffic: fill bursts and drain bursts walk the deque between full
	// and empty so the boundary cases keep coming, mixed stretches add noise
	task automatic run_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned burst;
		int unsigned mode;
		logic [OPCODE_W-1:0] op;
		sent = 0;
		while (sent < n_items) begin
			mode  = $urandom_range(2);
			burst = $urandom_range(24, 6);
			repeat (burst) begin
				case (mode)
					0: op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
					1: op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
					default: op = OPCODE_W'($urandom_range(7));
				endcase
				offer_item(op, pick_value());
				sent++;
			end
		end
	endtask

	// receiver: random stall, one long hold-off on request, checks every taken result
	initial begin
		deque_view_t got;
		int unsigned hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got.front = front_value;
				got.back  = back_value;
				got.cnt   = count;
				got.empty = is_empty;
				got.st    = status_t'(status);
				book.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 80;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// main sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender idles lightly, receiver heavily
		tx_idle_pct = 34;
		rx_idle_pct = 82;

		// directed: empty queue reads, single-element pops from both ends,
		// front pointer wrapping below zero, extreme values, unused opcodes
		offer_item(OP_PEEK,      $urandom);
		offer_item(OP_POP_FRONT, $urandom);
		offer_item(OP_POP_BACK,  $urandom);
		offer_item(OP_PUSH_BACK, 32'sh8000_0000);
		offer_item(OP_POP_BACK,  '0);
		offer_item(OP_PUSH_FRONT, 32'sh7fff_ffff);
		offer_item(OP_POP_FRONT, '1);
		offer_item(OP_PUSH_FRONT, '1);
		offer_item(OP_PUSH_BACK, '0);
		offer_item(OP_PUSH_FRONT, 32'sh8000_0000);
		offer_item(OP_PUSH_BACK, 32'sh7fff_ffff);
		offer_item(3'd5,         $urandom);
		offer_item(3'd6,         $urandom);
		offer_item(3'd7,         '1);
		offer_item(OP_POP_BACK,  $urandom);
		offer_item(OP_POP_FRONT, $urandom);
		offer_item(OP_POP_BACK,  $urandom);
		offer_item(OP_POP_FRONT, $urandom);
		offer_item(OP_POP_BACK,  $urandom);
		offer_item(OP_PUSH_BACK, 32'sh5555_5555);
		offer_item(OP_PUSH_FRONT, 32'shaaaa_aaaa);
		offer_item(OP_PEEK,      '0);

		run_random(400);

		// phase two: the other way round
		tx_idle_pct = 82;
		rx_idle_pct = 34;
		run_random(400);

		// phase three: no idling; the receiver holds off for a long stretch
		// while pushes keep coming, so the block backs up and the deque
		// itself runs full and drops pushes
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req    = 1'b1;
		repeat (20) offer_item($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
		run_random(380);

		in_valid <= 1'b0;

		// drain, then let the clock run on so that stray results would show up
		while (book.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (book.failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
